// ===== sv/bsp_region_locate_top_defines.svh =====
`ifndef BSP_REGION_LOCATE_TOP_DEFINES_SVH
`define BSP_REGION_LOCATE_TOP_DEFINES_SVH

// same-cycle implication
`define BSP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bsp assertion failed");

// next-cycle implication
`define BSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bsp assertion failed");

`endif

// ===== sv/bsp_pkg.sv =====
package bsp_pkg;

   localparam int LINK_W = 11;
   localparam int REGION_W = 16;
   localparam int COUNT_W = 7;
   localparam int MAX_RESULTS = 64;
   localparam int RES_AW = 6;

   typedef enum logic [1:0] {
      FUNC_WRITE = 2'd0,
      FUNC_POINT = 2'd1,
      FUNC_SPHERE = 2'd2,
      FUNC_NOP = 2'd3
   } func_type;

   typedef struct packed {
      logic [1:0] func;
      logic [10:0] node_slot;
      logic signed [31:0] vec_x;
      logic signed [31:0] vec_y;
      logic signed [31:0] vec_z;
      logic signed [31:0] scalar;
      logic [10:0] left_link;
      logic [10:0] right_link;
      logic [15:0] leaf_region;
   } req_type;

   typedef struct packed {
      logic [15:0] region;
      logic valid_res;
      logic last;
      logic [6:0] found_count;
      logic overflow;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] nx;
      logic signed [31:0] ny;
      logic signed [31:0] nz;
      logic signed [31:0] off;
      logic [LINK_W-1:0] left;
      logic [LINK_W-1:0] right;
      logic [REGION_W-1:0] region;
   } node_type;

endpackage

// ===== sv/bsp_ram.sv =====
module bsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/bsp_region_locate_top.sv =====
// node write: no result item; the next item can follow at once
// point lookup: per inner node visited (node ram read, three passes of one
//   shared 32x32 multiplier, distance add, decide), leaf read and lookup, response
// sphere query: same per node walked, S_POP per pop, then S_ERD, S_EOUT per result;
//   no new item is taken until the last result item of a query is loaded
// reset (synchronous, active high) clears control state, sets result_limit to 64, not rams
`include "bsp_region_locate_top_defines.svh"

module bsp_region_locate_top #(
   parameter int NODE_COUNT = 1024,
   parameter int STACK_DEPTH = 64
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  bsp_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output bsp_pkg::rsp_type rsp_data,
   input  logic csr_wr_en,
   input  logic [6:0] csr_wr_data
);

   localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
   localparam int VW = $clog2(NODE_COUNT + 1);
   localparam int SW = $clog2(STACK_DEPTH);
   localparam int TW = $clog2(STACK_DEPTH + 1);
   localparam int NW = $bits(bsp_pkg::node_type);
   localparam int LW = bsp_pkg::LINK_W;

   typedef enum logic [3:0] {
      S_IDLE, S_FETCH, S_LOOK, S_M1, S_M2, S_M3, S_DIST, S_DECIDE,
      S_POP, S_PRESP, S_ERD, S_EOUT
   } state_type;

   state_type state_ff;
   logic [LW-1:0] cur_ff;
   logic [VW-1:0] visits_ff;
   logic [TW-1:0] top_ff;
   logic [6:0] count_ff;
   logic [6:0] k_ff;
   logic ovf_ff;
   logic sphere_ff;
   logic [15:0] found_ff;
   logic [6:0] limit_ff;
   logic signed [31:0] px_ff, py_ff, pz_ff, rad_ff;
   logic signed [63:0] prod_ff;
   logic signed [65:0] acc_ff;
   logic signed [51:0] d_ff;
   logic rsp_valid_ff;
   bsp_pkg::rsp_type rsp_data_ff;

   bsp_pkg::node_type node_wr, node_rd;
   logic [NW-1:0] node_rd_raw;
   logic node_wr_en;
   logic [AW-1:0] node_wr_addr, node_rd_addr;
   logic stk_wr_en;
   logic [LW-1:0] stk_rd_data;
   logic res_wr_en;
   logic [15:0] res_rd_data;

   logic accept, out_free, cur_ok, slot_ok, rsp_load;
   logic [6:0] lim;
   logic signed [31:0] mul_a, mul_b;
   logic signed [51:0] rad_ext, neg_d;
   logic go_l, go_r;

   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_load = out_free && ((state_ff == S_PRESP && !(sphere_ff && count_ff != '0))
                                  || state_ff == S_EOUT);
   assign lim = (limit_ff > 7'(bsp_pkg::MAX_RESULTS)) ? 7'(bsp_pkg::MAX_RESULTS) : limit_ff;
   assign cur_ok = (cur_ff != '0) && (32'(cur_ff) <= NODE_COUNT);
   assign slot_ok = (req_data.node_slot != '0) && (32'(req_data.node_slot) <= NODE_COUNT);

   assign node_wr_en = accept && (req_data.func == bsp_pkg::FUNC_WRITE) && slot_ok;
   assign node_wr_addr = AW'(32'(req_data.node_slot) - 32'd1);
   assign node_rd_addr = AW'(32'(cur_ff) - 32'd1);
   assign node_wr.nx = req_data.vec_x;
   assign node_wr.ny = req_data.vec_y;
   assign node_wr.nz = req_data.vec_z;
   assign node_wr.off = req_data.scalar;
   assign node_wr.left = req_data.left_link;
   assign node_wr.right = req_data.right_link;
   assign node_wr.region = req_data.leaf_region;
   assign node_rd = bsp_pkg::node_type'(node_rd_raw);

   assign rad_ext = 52'(rad_ff);
   assign neg_d = -d_ff;
   assign go_l = !d_ff[51] || (rad_ext >= neg_d);
   assign go_r = d_ff[51] || (d_ff == '0) || (rad_ext >= d_ff);

   assign stk_wr_en = (state_ff == S_DECIDE) && sphere_ff && go_l && go_r
                      && (32'(top_ff) < STACK_DEPTH);
   assign res_wr_en = (state_ff == S_LOOK) && sphere_ff && (node_rd.region != '0);

   always_comb begin
      unique case (state_ff)
         S_M1: begin
            mul_a = node_rd.ny;
            mul_b = py_ff;
         end
         S_M2: begin
            mul_a = node_rd.nz;
            mul_b = pz_ff;
         end
         default: begin
            mul_a = node_rd.nx;
            mul_b = px_ff;
         end
      endcase
   end

   bsp_ram #(.WIDTH(NW), .DEPTH(NODE_COUNT)) u_node_ram (
      .clock(clock), .wr_en(node_wr_en), .wr_addr(node_wr_addr), .wr_data(node_wr),
      .rd_addr(node_rd_addr), .rd_data(node_rd_raw)
   );

   bsp_ram #(.WIDTH(LW), .DEPTH(STACK_DEPTH)) u_stack_ram (
      .clock(clock), .wr_en(stk_wr_en), .wr_addr(top_ff[SW-1:0]), .wr_data(node_rd.right),
      .rd_addr(SW'(top_ff - TW'(1))), .rd_data(stk_rd_data)
   );

   bsp_ram #(.WIDTH(16), .DEPTH(bsp_pkg::MAX_RESULTS)) u_result_ram (
      .clock(clock), .wr_en(res_wr_en), .wr_addr(count_ff[bsp_pkg::RES_AW-1:0]),
      .wr_data(node_rd.region), .rd_addr(k_ff[bsp_pkg::RES_AW-1:0]), .rd_data(res_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         top_ff <= '0;
         count_ff <= '0;
         k_ff <= '0;
         visits_ff <= '0;
         ovf_ff <= 1'b0;
         sphere_ff <= 1'b0;
         limit_ff <= 7'(bsp_pkg::MAX_RESULTS);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         if (rsp_valid_ff && !rsp_stall && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end
         prod_ff <= mul_a * mul_b;
         unique case (state_ff)
            S_IDLE: begin
               if (accept && (req_data.func == bsp_pkg::FUNC_POINT
                              || req_data.func == bsp_pkg::FUNC_SPHERE)) begin
                  sphere_ff <= (req_data.func == bsp_pkg::FUNC_SPHERE);
                  px_ff <= req_data.vec_x;
                  py_ff <= req_data.vec_y;
                  pz_ff <= req_data.vec_z;
                  rad_ff <= req_data.scalar;
                  cur_ff <= LW'(1);
                  visits_ff <= '0;
                  top_ff <= '0;
                  count_ff <= '0;
                  ovf_ff <= 1'b0;
                  found_ff <= '0;
                  state_ff <= S_FETCH;
               end
            end
            S_FETCH: begin
               if (!sphere_ff) begin
                  if (cur_ok && (32'(visits_ff) < NODE_COUNT)) begin
                     visits_ff <= visits_ff + VW'(1);
                     state_ff <= S_LOOK;
                  end else begin
                     found_ff <= '0;
                     state_ff <= S_PRESP;
                  end
               end else if (count_ff >= lim) begin
                  state_ff <= S_PRESP;
               end else if (!cur_ok) begin
                  if (top_ff == '0) begin
                     state_ff <= S_PRESP;
                  end else begin
                     top_ff <= top_ff - TW'(1);
                     state_ff <= S_POP;
                  end
               end else if (32'(visits_ff) >= NODE_COUNT) begin
                  ovf_ff <= 1'b1;
                  state_ff <= S_PRESP;
               end else begin
                  visits_ff <= visits_ff + VW'(1);
                  state_ff <= S_LOOK;
               end
            end
            S_LOOK: begin
               if (node_rd.region != '0) begin
                  if (sphere_ff) begin
                     count_ff <= count_ff + 7'd1;
                     cur_ff <= '0;
                     state_ff <= S_FETCH;
                  end else begin
                     found_ff <= node_rd.region;
                     state_ff <= S_PRESP;
                  end
               end else begin
                  state_ff <= S_M1;
               end
            end
            S_M1: begin
               acc_ff <= 66'(prod_ff);
               state_ff <= S_M2;
            end
            S_M2: begin
               acc_ff <= acc_ff + 66'(prod_ff);
               state_ff <= S_M3;
            end
            S_M3: begin
               acc_ff <= acc_ff + 66'(prod_ff);
               state_ff <= S_DIST;
            end
            S_DIST: begin
               d_ff <= 52'(acc_ff >>> 16) + 52'(node_rd.off);
               state_ff <= S_DECIDE;
            end
            S_DECIDE: begin
               if (!sphere_ff) begin
                  cur_ff <= d_ff[51] ? node_rd.right : node_rd.left;
               end else if (go_l && go_r) begin
                  if (32'(top_ff) < STACK_DEPTH) begin
                     top_ff <= top_ff + TW'(1);
                  end else begin
                     ovf_ff <= 1'b1;
                  end
                  cur_ff <= node_rd.left;
               end else if (go_l) begin
                  cur_ff <= node_rd.left;
               end else if (go_r) begin
                  cur_ff <= node_rd.right;
               end else begin
                  cur_ff <= '0;
               end
               state_ff <= S_FETCH;
            end
            S_POP: begin
               cur_ff <= stk_rd_data;
               state_ff <= S_FETCH;
            end
            S_PRESP: begin
               if (sphere_ff && count_ff != '0) begin
                  k_ff <= '0;
                  state_ff <= S_ERD;
               end else if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff.region <= found_ff;
                  rsp_data_ff.valid_res <= (found_ff != '0);
                  rsp_data_ff.last <= 1'b1;
                  rsp_data_ff.found_count <= (found_ff != '0) ? 7'd1 : 7'd0;
                  rsp_data_ff.overflow <= ovf_ff;
                  top_ff <= '0;
                  state_ff <= S_IDLE;
               end
            end
            S_ERD: begin
               state_ff <= S_EOUT;
            end
            S_EOUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff.region <= res_rd_data;
                  rsp_data_ff.valid_res <= 1'b1;
                  rsp_data_ff.last <= (k_ff + 7'd1 == count_ff);
                  rsp_data_ff.found_count <= k_ff + 7'd1;
                  rsp_data_ff.overflow <= ovf_ff;
                  k_ff <= k_ff + 7'd1;
                  if (k_ff + 7'd1 == count_ff) begin
                     top_ff <= '0;
                     state_ff <= S_IDLE;
                  end else begin
                     state_ff <= S_ERD;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   `BSP_ASSERT_NOW(a_stack_bound, clock, reset, 1'b1, 32'(top_ff) <= STACK_DEPTH)
   `BSP_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= 7'(bsp_pkg::MAX_RESULTS))
   `BSP_ASSERT_NOW(a_empty_item, clock, reset, rsp_valid_ff && !rsp_data_ff.valid_res,
      rsp_data_ff.found_count == '0 && rsp_data_ff.last)
   `BSP_ASSERT_NEXT(a_busy_stall, clock, reset, state_ff != S_IDLE && state_ff != S_PRESP
      && state_ff != S_EOUT, req_stall)

endmodule

// ===== dv/testbench.sv =====
module testbench;

   localparam int NODES = 1024;
   localparam int STACK_MAX = 64;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   bsp_pkg::req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   bsp_pkg::rsp_type rsp_data;
   logic csr_wr_en;
   logic [6:0] csr_wr_data;

   bsp_pkg::node_type node_tbl [1:NODES];
   int unsigned region_limit;
   bsp_pkg::rsp_type region_q[$];
   int errors;
   int items_sent;
   bit quiet;
   int stall_left;

   bsp_region_locate_top uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic bit link_good(logic [10:0] l);
      return l >= 1 && l <= NODES;
   endfunction

   function automatic logic signed [67:0] wide_mul(logic signed [31:0] a,
                                                    logic signed [31:0] b);
      logic signed [67:0] ea;
      logic signed [67:0] eb;
      ea = a;
      eb = b;
      return ea * eb;
   endfunction

   // exact sum of products, floored to q16.16, then offset at full width
   function automatic logic signed [67:0] plane_dist(bsp_pkg::node_type n,
                                                      bsp_pkg::req_type r);
      logic signed [67:0] s;
      logic signed [67:0] o;
      s = wide_mul(n.nx, r.vec_x) + wide_mul(n.ny, r.vec_y) + wide_mul(n.nz, r.vec_z);
      o = n.off;
      return (s >>> 16) + o;
   endfunction

   function automatic bsp_pkg::rsp_type mk_rsp(logic [15:0] reg_id, bit v, bit l,
                                               logic [6:0] cnt, bit ovf);
      bsp_pkg::rsp_type t;
      t.region = reg_id;
      t.valid_res = v;
      t.last = l;
      t.found_count = cnt;
      t.overflow = ovf;
      return t;
   endfunction

   function automatic void predict_regions(bsp_pkg::req_type r);
      logic [10:0] cur;
      int unsigned visits;
      int unsigned lim;
      logic [15:0] found;
      logic [15:0] regs[$];
      logic [10:0] stk[$];
      logic signed [67:0] d;
      logic signed [67:0] rad;
      bit ovf;
      bit go_l;
      bit go_r;
      bsp_pkg::node_type n;
      visits = 0;
      unique case (r.func)
         bsp_pkg::FUNC_WRITE: begin
            if (link_good(r.node_slot)) begin
               node_tbl[r.node_slot] = '{r.vec_x, r.vec_y, r.vec_z, r.scalar,
                                         r.left_link, r.right_link, r.leaf_region};
            end
         end
         bsp_pkg::FUNC_POINT: begin
            cur = 11'd1;
            found = 0;
            while (link_good(cur) && visits < NODES) begin
               n = node_tbl[cur];
               visits++;
               if (n.region != 0) begin
                  found = n.region;
                  break;
               end
               d = plane_dist(n, r);
               cur = (d >= 0) ? n.left : n.right;
            end
            region_q.insert(region_q.size(), mk_rsp(found, found != 0, 1'b1,
                                                    (found != 0) ? 7'd1 : 7'd0, 1'b0));
         end
         bsp_pkg::FUNC_SPHERE: begin
            lim = (region_limit > 64) ? 64 : region_limit;
            ovf = 0;
            cur = 11'd1;
            rad = r.scalar;
            forever begin
               if (regs.size() >= lim) break;
               if (!link_good(cur)) begin
                  if (stk.size() == 0) break;
                  cur = stk.pop_back();
                  continue;
               end
               if (visits >= NODES) begin
                  ovf = 1;
                  break;
               end
               visits++;
               n = node_tbl[cur];
               if (n.region != 0) begin
                  regs.insert(regs.size(), n.region);
                  cur = 11'd0;
               end else begin
                  d = plane_dist(n, r);
                  go_l = (d >= 0) || (rad >= -d);
                  go_r = (d <= 0) || (rad >= d);
                  if (go_l && go_r) begin
                     if (stk.size() < STACK_MAX) stk.insert(stk.size(), n.right);
                     else ovf = 1;
                     cur = n.left;
                  end else if (go_l) begin
                     cur = n.left;
                  end else if (go_r) begin
                     cur = n.right;
                  end else begin
                     cur = 11'd0;
                  end
               end
            end
            if (regs.size() == 0) begin
               region_q.insert(region_q.size(), mk_rsp(16'd0, 1'b0, 1'b1, 7'd0, ovf));
            end else begin
               foreach (regs[k]) begin
                  region_q.insert(region_q.size(), mk_rsp(regs[k], 1'b1,
                                                          k + 1 == regs.size(),
                                                          7'(k + 1), ovf));
               end
            end
         end
         default: begin
         end
      endcase
   endfunction

   task automatic send_item(bsp_pkg::req_type r);
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 11);
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_data = r;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      predict_regions(r);
      items_sent++;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (region_q.size() != 0) @(posedge clock);
      repeat (60) @(negedge clock);
   endtask

   task automatic set_limit(int unsigned v);
      wait_idle();
      csr_wr_en = 1'b1;
      csr_wr_data = 7'(v);
      @(negedge clock);
      csr_wr_en = 1'b0;
      region_limit = v;
   endtask

   function automatic bsp_pkg::req_type mk_node(logic [10:0] slot, logic [31:0] nx,
                                                logic [31:0] ny, logic [31:0] nz,
                                                logic [31:0] off, logic [10:0] l,
                                                logic [10:0] rt, logic [15:0] reg_id);
      bsp_pkg::req_type t;
      t.func = bsp_pkg::FUNC_WRITE;
      t.node_slot = slot;
      t.vec_x = nx;
      t.vec_y = ny;
      t.vec_z = nz;
      t.scalar = off;
      t.left_link = l;
      t.right_link = rt;
      t.leaf_region = reg_id;
      return t;
   endfunction

   function automatic bsp_pkg::req_type mk_query(bsp_pkg::func_type f, logic [31:0] x,
                                                 logic [31:0] y, logic [31:0] z,
                                                 logic [31:0] rad);
      bsp_pkg::req_type t;
      logic [191:0] noise;
      noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      t = bsp_pkg::req_type'(noise[$bits(bsp_pkg::req_type)-1:0]);
      t.func = f;
      t.vec_x = x;
      t.vec_y = y;
      t.vec_z = z;
      t.scalar = rad;
      return t;
   endfunction

   function automatic logic [31:0] rnd_fix();
      unique case ($urandom_range(0, 5))
         0: return $urandom;
         1: return 32'sh8000_0000;
         2: return 32'sh7fff_ffff;
         default: return 32'($urandom_range(0, 262144)) - 32'd131072;
      endcase
   endfunction

   function automatic logic [31:0] rnd_radius();
      unique case ($urandom_range(0, 4))
         0: return -32'sd65536 * $urandom_range(0, 4);
         1: return 32'sh7fff_ffff;
         2: return 32'd0;
         default: return 32'($urandom_range(0, 500000));
      endcase
   endfunction

   function automatic logic [10:0] rnd_null();
      return $urandom_range(0, 1) ? 11'd0 : 11'($urandom_range(NODES + 1, 2047));
   endfunction

   // children are written before parents; all but slot 1 link lower, so no cycles
   task automatic build_tree();
      int k;
      logic [10:0] l;
      logic [10:0] rt;
      k = $urandom_range(1, 12);
      for (int i = 2; i <= k + 1; i++) begin
         if (i == 2 || $urandom_range(0, 1)) begin
            send_item(mk_node(11'(i), rnd_fix(), rnd_fix(), rnd_fix(), rnd_fix(),
                              rnd_null(), rnd_null(), 16'($urandom_range(1, 65535))));
         end else begin
            l = $urandom_range(0, 3) ? 11'($urandom_range(2, i - 1)) : rnd_null();
            rt = $urandom_range(0, 3) ? 11'($urandom_range(2, i - 1)) : rnd_null();
            send_item(mk_node(11'(i), rnd_fix(), rnd_fix(), rnd_fix(), rnd_fix(),
                              l, rt, 16'd0));
         end
      end
      l = $urandom_range(0, 5) ? 11'($urandom_range(2, k + 1)) : rnd_null();
      rt = $urandom_range(0, 5) ? 11'($urandom_range(2, k + 1)) : rnd_null();
      send_item(mk_node(11'd1, rnd_fix(), rnd_fix(), rnd_fix(), rnd_fix(), l, rt, 16'd0));
   endtask

   task automatic send_noise();
      bsp_pkg::req_type t;
      logic [191:0] noise;
      noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      t = bsp_pkg::req_type'(noise[$bits(bsp_pkg::req_type)-1:0]);
      if ($urandom_range(0, 1)) begin
         t.func = bsp_pkg::FUNC_NOP;
      end else begin
         t.func = bsp_pkg::FUNC_WRITE;
         t.node_slot = $urandom_range(0, 1) ? 11'd0 : 11'($urandom_range(NODES + 1, 2047));
      end
      send_item(t);
   endtask

   task automatic test_point_basic();
      send_item(mk_node(11'd1, 32'sh0001_0000, 32'd0, 32'd0, 32'd0, 11'd2, 11'd3, 16'd0));
      send_item(mk_node(11'd2, 32'd0, 32'd0, 32'd0, 32'd0, 11'd0, 11'd0, 16'hffff));
      send_item(mk_node(11'd3, 32'd0, 32'd0, 32'd0, 32'd0, 11'd0, 11'd0, 16'd1));
      send_item(mk_query(bsp_pkg::FUNC_POINT, 32'sh0000_0001, 32'd0, 32'd0, 32'd0));
      send_item(mk_query(bsp_pkg::FUNC_POINT, 32'sh8000_0000, 32'd5, 32'd5, 32'd0));
      send_item(mk_query(bsp_pkg::FUNC_POINT, 32'd0, 32'd0, 32'd0, 32'd0));
      send_item(mk_node(11'd1024, 32'd0, 32'd0, 32'd0, 32'd0, 11'd0, 11'd0, 16'h8000));
      send_item(mk_node(11'd1, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
                        32'sh8000_0000, 11'd1024, 11'h7ff, 16'd0));
      send_item(mk_query(bsp_pkg::FUNC_POINT, 32'sh7fff_ffff, 32'sh7fff_ffff,
                         32'sh8000_0000, 32'd0));
      send_item(mk_query(bsp_pkg::FUNC_POINT, 32'sh8000_0000, 32'sh8000_0000,
                         32'sh8000_0000, 32'd0));
   endtask

   task automatic test_sphere_basic();
      send_item(mk_node(11'd1, 32'sh0001_0000, 32'd0, 32'd0, 32'd0, 11'd2, 11'd3, 16'd0));
      send_item(mk_query(bsp_pkg::FUNC_SPHERE, 32'sh0002_0000, 32'd0, 32'd0,
                         32'sh0001_0000));
      send_item(mk_query(bsp_pkg::FUNC_SPHERE, 32'sh0002_0000, 32'd0, 32'd0,
                         32'sh0003_0000));
      send_item(mk_query(bsp_pkg::FUNC_SPHERE, 32'shfffe_0000, 32'd0, 32'd0,
                         32'sh8000_0000));
      send_item(mk_node(11'd1, 32'd0, 32'd0, 32'd0, 32'd0, 11'd0, 11'h7ff, 16'd0));
      send_item(mk_query(bsp_pkg::FUNC_SPHERE, 32'd0, 32'd0, 32'd0, 32'sh7fff_ffff));
   endtask

   // node 1 links to itself on both sides: stack fills, visit cap is reached
   task automatic test_self_cycle();
      send_item(mk_node(11'd1, 32'd0, 32'd0, 32'd0, 32'd0, 11'd1, 11'd1, 16'd0));
      send_item(mk_query(bsp_pkg::FUNC_SPHERE, 32'd0, 32'd0, 32'd0, 32'd0));
      send_item(mk_query(bsp_pkg::FUNC_POINT, 32'd0, 32'd0, 32'd0, 32'd0));
   endtask

   task automatic test_limits();
      build_tree();
      send_item(mk_query(bsp_pkg::FUNC_SPHERE, rnd_fix(), rnd_fix(), rnd_fix(),
                         32'sh7fff_ffff));
      set_limit(0);
      send_item(mk_query(bsp_pkg::FUNC_SPHERE, rnd_fix(), rnd_fix(), rnd_fix(),
                         32'sh7fff_ffff));
      set_limit(1);
      send_item(mk_query(bsp_pkg::FUNC_SPHERE, rnd_fix(), rnd_fix(), rnd_fix(),
                         32'sh7fff_ffff));
      set_limit(127);
      send_item(mk_query(bsp_pkg::FUNC_SPHERE, rnd_fix(), rnd_fix(), rnd_fix(),
                         32'sh7fff_ffff));
      set_limit(64);
   endtask

   task automatic test_ignored();
      send_noise();
      send_noise();
      send_item(mk_query(bsp_pkg::FUNC_POINT, rnd_fix(), rnd_fix(), rnd_fix(),
                         rnd_radius()));
   endtask

   task automatic test_random();
      int pick;
      while (items_sent < 210) begin
         if (items_sent > 180) quiet = 1;
         pick = $urandom_range(0, 19);
         if (pick < 4) begin
            build_tree();
         end else if (pick < 6) begin
            send_noise();
         end else if (pick == 6 && !quiet) begin
            set_limit($urandom_range(0, 3) ? $urandom_range(1, 8) : $urandom_range(0, 127));
         end else begin
            send_item(mk_query($urandom_range(0, 1) ? bsp_pkg::FUNC_SPHERE
                                                    : bsp_pkg::FUNC_POINT,
                               rnd_fix(), rnd_fix(), rnd_fix(), rnd_radius()));
         end
      end
   endtask

   initial begin
      rsp_stall = 1'b0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (region_q.size() == 0) begin
               $error("unexpected item region %0h", rsp_data.region);
               errors++;
            end else begin
               bsp_pkg::rsp_type w;
               w = region_q.pop_front();
               if (rsp_data.region !== w.region) begin
                  $error("region expected %0h actual %0h", w.region, rsp_data.region);
                  errors++;
               end
               if (rsp_data.valid_res !== w.valid_res) begin
                  $error("valid_res expected %0b actual %0b", w.valid_res,
                         rsp_data.valid_res);
                  errors++;
               end
               if (rsp_data.last !== w.last) begin
                  $error("last expected %0b actual %0b", w.last, rsp_data.last);
                  errors++;
               end
               if (rsp_data.found_count !== w.found_count) begin
                  $error("found_count expected %0d actual %0d", w.found_count,
                         rsp_data.found_count);
                  errors++;
               end
               if (rsp_data.overflow !== w.overflow) begin
                  $error("overflow expected %0b actual %0b", w.overflow, rsp_data.overflow);
                  errors++;
               end
            end
         end
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 11);
         end
         if (quiet) stall_left = 0;
         rsp_stall = stall_left > 0;
      end
   end

   initial begin
      #100000000;
      $display("testbench failed");
      $finish;
   end

   initial begin
      errors = 0;
      items_sent = 0;
      quiet = 0;
      region_limit = 64;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      repeat (9) @(negedge clock);
      reset = 1'b0;
      test_point_basic();
      test_sphere_basic();
      test_self_cycle();
      test_ignored();
      test_limits();
      test_random();
      @(negedge clock);
      req_valid = 1'b0;
      while (region_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (errors == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end
endmodule
